// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the page parser module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ogpv_pkg.sv
// ----------------------------------------------------------------------------
// ogpv_pkg
// Types, constants and the CRC byte update shared by the page validator.
// ----------------------------------------------------------------------------
package ogpv_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_END,
        KIND_FIRST_BYTE,
        KIND_FIRST_END
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } item_t;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_TABLE,
        PH_BODY,
        PH_DONE
    } phase_t;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_CAPTURE   = 4'd1,
        ST_VERSION   = 4'd2,
        ST_NO_BOS    = 4'd3,
        ST_CONTINUED = 4'd4,
        ST_NO_SEGS   = 4'd5,
        ST_EMPTY     = 4'd6,
        ST_CRC_BAD   = 4'd7,
        ST_TRUNCATED = 4'd8
    } status_t;

    localparam logic [31:0] CRC_POLY     = 32'h04C11DB7;
    localparam logic [7:0]  CAPTURE [4]  = '{8'h4F, 8'h67, 8'h67, 8'h53};
    localparam int unsigned FLAG_BOS_BIT  = 1;
    localparam int unsigned FLAG_CONT_BIT = 0;
    localparam logic [4:0]  POS_VERSION  = 5'd4;
    localparam logic [4:0]  POS_FLAGS    = 5'd5;
    localparam logic [4:0]  POS_CRC_LO   = 5'd22;
    localparam logic [4:0]  POS_CRC_HI   = 5'd25;
    localparam logic [4:0]  POS_SEGS     = 5'd26;

    // One byte of the MSB-first CRC-32, eight shift steps.
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {b, 24'h000000};
        for (int i = 0; i < 8; i++) begin
            r = r[31] ? ({r[30:0], 1'b0} ^ CRC_POLY) : {r[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// File: hdl/ogpv_front.sv
// ----------------------------------------------------------------------------
// ogpv_front
// Input stage: accepts words, tags each as byte, end, or start of a file.
// ----------------------------------------------------------------------------
module ogpv_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [7:0]      s_axis_tdata,
    input  logic [1:0]      s_axis_tuser,
    output logic            push_valid,
    input  logic            push_ready,
    output ogpv_pkg::item_t push_item
);

    logic            valid_reg, valid_next;
    ogpv_pkg::item_t item_reg, item_next;
    ogpv_pkg::kind_t kind;

    always_comb begin
        case (s_axis_tuser)
            2'b01:   kind = ogpv_pkg::KIND_FIRST_BYTE;
            2'b10:   kind = ogpv_pkg::KIND_END;
            2'b11:   kind = ogpv_pkg::KIND_FIRST_END;
            default: kind = ogpv_pkg::KIND_BYTE;
        endcase
    end

    assign s_axis_tready = !valid_reg || push_ready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_axis_tvalid && s_axis_tready) begin
            valid_next     = 1'b1;
            item_next.kind = kind;
            item_next.data = s_axis_tdata;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign push_valid = valid_reg;
    assign push_item  = item_reg;

endmodule

// File: hdl/ogpv_fifo.sv
// ----------------------------------------------------------------------------
// ogpv_fifo
// Short queue of tagged items between the input stage and the parser.
// ----------------------------------------------------------------------------
module ogpv_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  ogpv_pkg::item_t wr_item,
    output logic            rd_valid,
    input  logic            rd_ready,
    output ogpv_pkg::item_t rd_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    ogpv_pkg::item_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push, pop;

    assign wr_ready = (count_reg != FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// File: hdl/ogpv_back.sv
// ----------------------------------------------------------------------------
// ogpv_back
// Page parser: header checks, lacing sum, CRC, and the verdict register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ogpv_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  ogpv_pkg::item_t q_item,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [7:0]      m_axis_tdata
);

    ogpv_pkg::phase_t  phase_reg, phase_next, eff_phase;
    logic [4:0]        pos_reg, pos_next, eff_pos;
    logic [7:0]        total_reg, total_next, eff_total;
    logic [7:0]        seen_reg, seen_next, eff_seen;
    logic [15:0]       body_reg, body_next, eff_body;
    logic [31:0]       crc_reg, crc_next, eff_crc;
    logic [31:0]       stored_reg, stored_next, eff_stored;

    logic              out_valid_reg, out_valid_next;
    logic              out_ok_reg, out_ok_next;
    ogpv_pkg::status_t out_status_reg, out_status_next;

    logic              take, sof, eof;
    logic [7:0]        b;
    logic              in_crc_field;
    logic [31:0]       crc_upd;
    logic [7:0]        seen_inc;
    logic [15:0]       body_add, body_dec;
    logic [1:0]        lane;
    logic              hit;
    ogpv_pkg::status_t code;

    assign q_ready = !out_valid_reg || m_axis_tready;
    assign take    = q_valid && q_ready;
    assign b       = q_item.data;
    assign sof     = (q_item.kind == ogpv_pkg::KIND_FIRST_BYTE)
                  || (q_item.kind == ogpv_pkg::KIND_FIRST_END);
    assign eof     = (q_item.kind == ogpv_pkg::KIND_END)
                  || (q_item.kind == ogpv_pkg::KIND_FIRST_END);

    // A start-of-file word sees the parser as just reset.
    assign eff_phase  = sof ? ogpv_pkg::PH_HEADER : phase_reg;
    assign eff_pos    = sof ? '0 : pos_reg;
    assign eff_total  = sof ? '0 : total_reg;
    assign eff_seen   = sof ? '0 : seen_reg;
    assign eff_body   = sof ? '0 : body_reg;
    assign eff_crc    = sof ? '0 : crc_reg;
    assign eff_stored = sof ? '0 : stored_reg;

    assign in_crc_field = (eff_pos >= ogpv_pkg::POS_CRC_LO) && (eff_pos <= ogpv_pkg::POS_CRC_HI);
    assign crc_upd  = ogpv_pkg::crc_byte(eff_crc,
                          (eff_phase == ogpv_pkg::PH_HEADER && in_crc_field) ? 8'h00 : b);
    assign seen_inc = eff_seen + 8'd1;
    assign body_add = eff_body + {8'h00, b};
    assign body_dec = eff_body - 16'd1;
    assign lane     = 2'(eff_pos - ogpv_pkg::POS_CRC_LO);

    // Verdict decode.
    always_comb begin
        hit  = 1'b0;
        code = ogpv_pkg::ST_OK;
        if (eff_phase != ogpv_pkg::PH_DONE) begin
            if (eof) begin
                hit  = 1'b1;
                code = ogpv_pkg::ST_TRUNCATED;
            end else begin
                case (eff_phase)
                    ogpv_pkg::PH_HEADER: begin
                        if (eff_pos < ogpv_pkg::POS_VERSION
                            && b != ogpv_pkg::CAPTURE[eff_pos[1:0]]) begin
                            hit  = 1'b1;
                            code = ogpv_pkg::ST_CAPTURE;
                        end else if (eff_pos == ogpv_pkg::POS_VERSION && b != 8'h00) begin
                            hit  = 1'b1;
                            code = ogpv_pkg::ST_VERSION;
                        end else if (eff_pos == ogpv_pkg::POS_FLAGS
                                     && !b[ogpv_pkg::FLAG_BOS_BIT]) begin
                            hit  = 1'b1;
                            code = ogpv_pkg::ST_NO_BOS;
                        end else if (eff_pos == ogpv_pkg::POS_FLAGS
                                     && b[ogpv_pkg::FLAG_CONT_BIT]) begin
                            hit  = 1'b1;
                            code = ogpv_pkg::ST_CONTINUED;
                        end else if (eff_pos == ogpv_pkg::POS_SEGS && b == 8'h00) begin
                            hit  = 1'b1;
                            code = ogpv_pkg::ST_NO_SEGS;
                        end
                    end
                    ogpv_pkg::PH_TABLE: begin
                        if (seen_inc >= eff_total && body_add == 16'h0000) begin
                            hit  = 1'b1;
                            code = ogpv_pkg::ST_EMPTY;
                        end
                    end
                    ogpv_pkg::PH_BODY: begin
                        if (body_dec == 16'h0000) begin
                            hit  = 1'b1;
                            code = (crc_upd == eff_stored) ? ogpv_pkg::ST_OK
                                                           : ogpv_pkg::ST_CRC_BAD;
                        end
                    end
                    default: begin
                        hit = 1'b0;
                    end
                endcase
            end
        end
    end

    // Next state of the parser.
    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        total_next  = total_reg;
        seen_next   = seen_reg;
        body_next   = body_reg;
        crc_next    = crc_reg;
        stored_next = stored_reg;
        if (take) begin
            phase_next  = eff_phase;
            pos_next    = eff_pos;
            total_next  = eff_total;
            seen_next   = eff_seen;
            body_next   = eff_body;
            crc_next    = eff_crc;
            stored_next = eff_stored;
            if (eff_phase != ogpv_pkg::PH_DONE) begin
                if (eof) begin
                    phase_next = ogpv_pkg::PH_DONE;
                end else begin
                    case (eff_phase)
                        ogpv_pkg::PH_HEADER: begin
                            crc_next = crc_upd;
                            pos_next = eff_pos + 5'd1;
                            if (in_crc_field) begin
                                stored_next = eff_stored | ({24'h000000, b} << {lane, 3'b000});
                            end
                            if (hit) begin
                                phase_next = ogpv_pkg::PH_DONE;
                            end else if (eff_pos == ogpv_pkg::POS_SEGS) begin
                                total_next = b;
                                seen_next  = '0;
                                body_next  = '0;
                                phase_next = ogpv_pkg::PH_TABLE;
                            end
                        end
                        ogpv_pkg::PH_TABLE: begin
                            crc_next  = crc_upd;
                            body_next = body_add;
                            seen_next = seen_inc;
                            if (seen_inc >= eff_total) begin
                                phase_next = hit ? ogpv_pkg::PH_DONE : ogpv_pkg::PH_BODY;
                            end
                        end
                        ogpv_pkg::PH_BODY: begin
                            crc_next  = crc_upd;
                            body_next = body_dec;
                            if (hit) begin
                                phase_next = ogpv_pkg::PH_DONE;
                            end
                        end
                        default: begin
                            phase_next = ogpv_pkg::PH_DONE;
                        end
                    endcase
                end
            end
        end
    end

    // Result register.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_ok_next     = out_ok_reg;
        out_status_next = out_status_reg;
        if (take && hit) begin
            out_valid_next  = 1'b1;
            out_ok_next     = (code == ogpv_pkg::ST_OK);
            out_status_next = code;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= ogpv_pkg::PH_HEADER;
            pos_reg       <= '0;
            total_reg     <= '0;
            seen_reg      <= '0;
            body_reg      <= '0;
            crc_reg       <= '0;
            stored_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            total_reg     <= total_next;
            seen_reg      <= seen_next;
            body_reg      <= body_next;
            crc_reg       <= crc_next;
            stored_reg    <= stored_next;
            out_valid_reg <= out_valid_next;
        end
        out_ok_reg     <= out_ok_next;
        out_status_reg <= out_status_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_status_reg, out_ok_reg};

    `ASSERT_IMPLIES(a_ok_flag, aclk, aresetn, out_valid_reg,
                    out_ok_reg == (out_status_reg == ogpv_pkg::ST_OK),
                    "is_valid disagrees with status")
    `ASSERT_IMPLIES(a_table_count, aclk, aresetn, phase_reg == ogpv_pkg::PH_TABLE,
                    seen_reg < total_reg, "segment table overran its count")
    `ASSERT_IMPLIES(a_body_left, aclk, aresetn, phase_reg == ogpv_pkg::PH_BODY,
                    body_reg != 16'h0000, "body phase with nothing left")
    `ASSERT_NEXT(a_done_after_verdict, aclk, aresetn, take && hit,
                 phase_reg == ogpv_pkg::PH_DONE, "parser not closed after a verdict")

endmodule

// File: hdl/ogg_first_page_validator.sv
// Path: a word is registered by the input stage and written into the queue; a word that
// gives a verdict loads the verdict register. Throughput: one word per cycle while no
// verdict waits on m_axis_tready; the CRC takes a whole byte per cycle in one XOR network.
// Reset: synchronous, aresetn low; the parser returns to the header phase with a
// zero CRC, the queue empties and no verdict is pending. No clearing pass is needed.
// ----------------------------------------------------------------------------
// ogg_first_page_validator
// Checks the first Ogg page of a byte stream and gives one verdict per file.
// ----------------------------------------------------------------------------
module ogg_first_page_validator #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Byte stream in.
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0] s_axis_tuser,   // [0] start_of_file, [1] end_of_file
    // Verdict out.
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] is_valid, [4:1] status, [7:5] zero
);

    // The front stage registers each word and tags it; the queue holds up
    // to QUEUE_DEPTH words while the parser stalls on the result side, and
    // lets the input stall without starving the parser.
    logic            push_valid, push_ready;
    ogpv_pkg::item_t push_item;
    logic            q_valid, q_ready;
    ogpv_pkg::item_t q_item;

    ogpv_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    ogpv_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_item  (push_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    // The parser consumes a word whenever its verdict register is free or
    // being emptied in the same cycle; words that give no verdict pass
    // through without touching the output.
    ogpv_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
